>>> hdl/sdf8_pkg.sv
//------------------------------------------------------------------------------
// sdf8_pkg
// Shared types and constants for the 8SSEDT signed distance field unit.
//------------------------------------------------------------------------------
package sdf8_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int COORD_BITS_DEF = 16;
    localparam int FAR_COORD      = 9999;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WIDTH     = 2'd1;
    localparam logic [1:0] REG_HEIGHT    = 2'd2;
    localparam logic [1:0] REG_BIAS      = 2'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

endpackage

>>> hdl/sdf8_isqrt.sv
//------------------------------------------------------------------------------
// sdf8_isqrt
// Iterative floor integer square root, one result bit per cycle.
//------------------------------------------------------------------------------
module sdf8_isqrt #(
    parameter int IN_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [IN_BITS-1:0]   i_value,
    output logic                 o_busy,
    output logic [IN_BITS/2-1:0] o_root
);
    localparam int RB = IN_BITS / 2;
    localparam int CB = $clog2(RB + 1);

    logic [RB-1:0]      r_root;
    logic [CB-1:0]      r_cnt;
    logic               r_busy;
    logic [IN_BITS-1:0] r_src;
    logic [RB+1:0]      w_part;
    logic [RB+1:0]      w_test;
    logic [RB+1:0]      r_pr;

    // Shift-subtract: consume two input bits per step.
    assign w_part = {r_pr[RB-1:0], r_src[IN_BITS-1 -: 2]};
    assign w_test = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CB'(RB);
            r_src  <= i_value;
            r_pr   <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_src <= r_src << 2;
            if (w_part >= w_test) begin
                r_pr   <= w_part - w_test;
                r_root <= {r_root[RB-2:0], 1'b1};
            end else begin
                r_pr   <= w_part;
                r_root <= {r_root[RB-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CB'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy | i_start;
    assign o_root = r_root;
endmodule

>>> hdl/sdf8_relax.sv
//------------------------------------------------------------------------------
// sdf8_relax
// Shared compare unit: offsets a neighbor vector and keeps the shorter one.
//------------------------------------------------------------------------------
module sdf8_relax #(
    parameter int CB = 16
) (
    input  logic signed [CB-1:0] i_px,
    input  logic signed [CB-1:0] i_py,
    input  logic signed [CB-1:0] i_nx,
    input  logic signed [CB-1:0] i_ny,
    input  logic signed [1:0]    i_ox,
    input  logic signed [1:0]    i_oy,
    output logic signed [CB-1:0] o_x,
    output logic signed [CB-1:0] o_y
);
    logic signed [CB-1:0]   w_cx, w_cy;
    logic        [2*CB:0]   w_lc, w_lp;

    assign w_cx = i_nx + CB'(i_ox);
    assign w_cy = i_ny + CB'(i_oy);
    assign w_lc = (2*CB+1)'(w_cx) * (2*CB+1)'(w_cx) + (2*CB+1)'(w_cy) * (2*CB+1)'(w_cy);
    assign w_lp = (2*CB+1)'(i_px) * (2*CB+1)'(i_px) + (2*CB+1)'(i_py) * (2*CB+1)'(i_py);
    assign o_x  = (w_lc < w_lp) ? w_cx : i_px;
    assign o_y  = (w_lc < w_lp) ? w_cy : i_py;
endmodule

>>> hdl/signed_distance_field_8ssedt_unit.sv
//------------------------------------------------------------------------------
// signed_distance_field_8ssedt_unit
// Loads a frame, runs 8SSEDT on both grids, reads out biased distances.
//
// Channel | Ports                               | Handshake
// cmd     | i_operation, i_pixel                | i_start & !o_busy
// result  | o_distance_value, o_frame_last,     | o_valid, one cycle
//         |   o_ready_res                       |
// config  | i_cfg_we, i_cfg_index, i_cfg_data   | i_cfg_we
//
// A load holds busy while in S_LOAD; the last load of a frame also runs the
// transform: each pixel visit reads the pixel, then each neighbor in turn,
// through a memory with one read port, then writes it back and advances. A
// read holds busy for two sequential square roots; a read with no frame
// answers at once. The receiver cannot stall results.
// Synchronous reset clears control only; grids are written before read.
//------------------------------------------------------------------------------
module signed_distance_field_8ssedt_unit #(
    parameter int MAX_WIDTH  = sdf8_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sdf8_pkg::MAX_HEIGHT_DEF,
    parameter int COORD_BITS = sdf8_pkg::COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_operation,
    input  logic [7:0] i_pixel,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data,
    output logic       o_busy,
    output logic       o_valid,
    output logic [7:0] o_distance_value,
    output logic       o_frame_last,
    output logic       o_ready_res
);
    localparam int CB    = COORD_BITS;
    localparam int XB    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AB    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SB    = 2 * CB + 2;
    localparam int RB    = SB / 2;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_PRD, S_PWAIT, S_NRD, S_NWAIT, S_NEXT, S_WR,
        S_RRD, S_RWAIT, S_SQO, S_SQI, S_OUT
    } t_state;

    logic signed [CB-1:0] r_mem_x [2][CELLS];
    logic signed [CB-1:0] r_mem_y [2][CELLS];

    t_state               r_state;
    logic [7:0]           r_thr, r_bias;
    logic [8:0]           r_w, r_h;
    logic [AB:0]          r_load;
    logic [AB-1:0]        r_ridx;
    logic                 r_done;
    logic                 r_grid;
    logic [1:0]           r_scan;
    logic [XB-1:0]        r_x;
    logic [YB-1:0]        r_y;
    logic [2:0]           r_nb;
    logic signed [CB-1:0] r_px, r_py;
    logic signed [CB-1:0] r_rx, r_ry;
    logic                 r_rout;
    logic                 r_op;
    logic [7:0]           r_pix;
    logic                 r_valid;
    logic [7:0]           r_dv;
    logic                 r_last, r_rdy;
    logic [RB-1:0]        r_ro;
    logic                 r_sq_go;
    logic [SB-1:0]        r_sq_in;

    logic [XW-1:0]        w_ew;
    logic [YW-1:0]        w_eh;
    logic [AB:0]          w_total;
    logic [AB-1:0]        w_addr;
    logic signed [1:0]    w_ox, w_oy;
    logic [2:0]           w_nmax;
    logic signed [XB+1:0] w_nx;
    logic signed [YB+1:0] w_ny;
    logic                 w_out;
    logic signed [CB-1:0] w_rx, w_ry;
    logic                 w_sq_busy;
    logic [RB-1:0]        w_root;
    logic [AB-1:0]        w_cur;
    logic signed [RB+9:0] w_d;
    logic [SB-1:0]        w_lsq;

    assign w_ew = (r_w == 9'd0) ? XW'(1) :
                  (32'(r_w) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(r_w);
    assign w_eh = (r_h == 9'd0) ? YW'(1) :
                  (32'(r_h) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(r_h);
    assign w_total = (AB+1)'(w_ew) * (AB+1)'(w_eh);

    always_comb begin
        w_ox = 2'sd0;
        w_oy = 2'sd0;
        w_nmax = 3'd0;
        case (r_scan)
            2'd0: begin
                w_nmax = 3'd3;
                case (r_nb)
                    3'd0: begin w_ox = -2'sd1; w_oy = 2'sd0; end
                    3'd1: begin w_ox = 2'sd0; w_oy = -2'sd1; end
                    3'd2: begin w_ox = -2'sd1; w_oy = -2'sd1; end
                    default: begin w_ox = 2'sd1; w_oy = -2'sd1; end
                endcase
            end
            2'd1: begin w_ox = 2'sd1; w_oy = 2'sd0; end
            2'd2: begin
                w_nmax = 3'd3;
                case (r_nb)
                    3'd0: begin w_ox = 2'sd1; w_oy = 2'sd0; end
                    3'd1: begin w_ox = 2'sd0; w_oy = 2'sd1; end
                    3'd2: begin w_ox = -2'sd1; w_oy = 2'sd1; end
                    default: begin w_ox = 2'sd1; w_oy = 2'sd1; end
                endcase
            end
            default: begin w_ox = -2'sd1; w_oy = 2'sd0; end
        endcase
    end

    assign w_nx  = $signed({2'b00, r_x}) + (XB+2)'(w_ox);
    assign w_ny  = $signed({2'b00, r_y}) + (YB+2)'(w_oy);
    assign w_out = (w_nx < 0) || (w_ny < 0) ||
                   (w_nx >= $signed((XB+2)'(w_ew))) || (w_ny >= $signed((YB+2)'(w_eh)));
    assign w_cur = AB'(r_y) * AB'(w_ew) + AB'(r_x);

    always_comb begin
        w_addr = w_cur;
        if (r_state == S_NRD) begin
            w_addr = AB'(w_ny[YB-1:0]) * AB'(w_ew) + AB'(w_nx[XB-1:0]);
        end else if (r_state == S_RRD) begin
            w_addr = r_ridx;
        end
    end

    sdf8_relax #(.CB(CB)) u_relax (
        .i_px(r_px), .i_py(r_py),
        .i_nx(r_rout ? CB'(sdf8_pkg::FAR_COORD) : r_rx),
        .i_ny(r_rout ? CB'(sdf8_pkg::FAR_COORD) : r_ry),
        .i_ox(w_ox), .i_oy(w_oy), .o_x(w_rx), .o_y(w_ry)
    );

    sdf8_isqrt #(.IN_BITS(SB)) u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_sq_go),
        .i_value(r_sq_in), .o_busy(w_sq_busy), .o_root(w_root)
    );

    assign w_lsq = SB'(r_px) * SB'(r_px) + SB'(r_py) * SB'(r_py);
    assign w_d   = $signed({10'b0, r_ro}) - $signed({10'b0, w_root})
                 + $signed((RB+10)'(r_bias));

    // Memory port: registered read, single write.
    always_ff @(posedge i_clk) begin
        r_rx <= r_mem_x[r_grid][w_addr];
        r_ry <= r_mem_y[r_grid][w_addr];
        if (r_state == S_LOAD) begin
            r_mem_x[0][r_load[AB-1:0]] <= (r_pix < r_thr) ? '0 : CB'(sdf8_pkg::FAR_COORD);
            r_mem_y[0][r_load[AB-1:0]] <= (r_pix < r_thr) ? '0 : CB'(sdf8_pkg::FAR_COORD);
            r_mem_x[1][r_load[AB-1:0]] <= (r_pix < r_thr) ? CB'(sdf8_pkg::FAR_COORD) : '0;
            r_mem_y[1][r_load[AB-1:0]] <= (r_pix < r_thr) ? CB'(sdf8_pkg::FAR_COORD) : '0;
        end else if (r_state == S_WR) begin
            r_mem_x[r_grid][w_cur] <= r_px;
            r_mem_y[r_grid][w_cur] <= r_py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_thr   <= 8'd128;
            r_bias  <= 8'd128;
            r_w     <= 9'd256;
            r_h     <= 9'd256;
            r_load  <= '0;
            r_ridx  <= '0;
            r_done  <= 1'b0;
            r_valid <= 1'b0;
            r_sq_go <= 1'b0;
            r_grid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_sq_go <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sdf8_pkg::REG_THRESHOLD: r_thr <= i_cfg_data[7:0];
                    sdf8_pkg::REG_WIDTH: begin
                        r_w <= i_cfg_data; r_load <= '0; r_ridx <= '0; r_done <= 1'b0;
                    end
                    sdf8_pkg::REG_HEIGHT: begin
                        r_h <= i_cfg_data; r_load <= '0; r_ridx <= '0; r_done <= 1'b0;
                    end
                    sdf8_pkg::REG_BIAS: r_bias <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op  <= i_operation;
                        r_pix <= i_pixel;
                        if (i_operation == sdf8_pkg::OP_LOAD) begin
                            if (r_load == '0) begin
                                r_done <= 1'b0;
                                r_ridx <= '0;
                            end
                            if (r_load >= w_total) r_load <= '0;
                            r_state <= S_LOAD;
                        end else if (!r_done) begin
                            r_dv <= 8'd0; r_last <= 1'b0; r_rdy <= 1'b0;
                            r_valid <= 1'b1;
                        end else begin
                            r_grid  <= 1'b1;
                            r_state <= S_RRD;
                        end
                    end
                end
                S_LOAD: begin
                    if (r_load + 1'b1 == w_total) begin
                        r_load  <= '0;
                        r_grid  <= 1'b0;
                        r_scan  <= 2'd0;
                        r_x     <= '0;
                        r_y     <= '0;
                        r_state <= S_PRD;
                    end else begin
                        r_load  <= r_load + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_PRD: begin
                    r_nb <= 3'd0;
                    r_state <= S_PWAIT;
                end
                S_PWAIT: begin
                    r_px <= r_rx;
                    r_py <= r_ry;
                    r_state <= S_NRD;
                end
                S_NRD: begin
                    r_rout  <= w_out;
                    r_state <= S_NWAIT;
                end
                S_NWAIT: begin
                    r_px <= w_rx;
                    r_py <= w_ry;
                    if (r_nb == w_nmax) begin
                        r_state <= S_WR;
                    end else begin
                        r_nb <= r_nb + 1'b1;
                        r_state <= S_NRD;
                    end
                end
                S_WR: r_state <= S_NEXT;
                S_NEXT: begin
                    r_state <= S_PRD;
                    // advance along the scan; rows flip scans at their ends
                    case (r_scan)
                        2'd0: begin
                            if (32'(r_x) == 32'(w_ew) - 1) r_scan <= 2'd1;
                            else r_x <= r_x + 1'b1;
                        end
                        2'd1: begin
                            if (r_x == '0) begin
                                if (32'(r_y) == 32'(w_eh) - 1) begin
                                    r_scan <= 2'd2;
                                    r_x <= XB'(32'(w_ew) - 1);
                                end else begin
                                    r_scan <= 2'd0;
                                    r_y <= r_y + 1'b1;
                                end
                            end else r_x <= r_x - 1'b1;
                        end
                        2'd2: begin
                            if (r_x == '0) r_scan <= 2'd3;
                            else r_x <= r_x - 1'b1;
                        end
                        default: begin
                            if (32'(r_x) == 32'(w_ew) - 1) begin
                                if (r_y == '0) begin
                                    if (r_grid) begin
                                        r_done <= 1'b1;
                                        r_ridx <= '0;
                                        r_state <= S_IDLE;
                                    end else begin
                                        r_grid <= 1'b1;
                                        r_scan <= 2'd0;
                                        r_x <= '0;
                                    end
                                end else begin
                                    r_scan <= 2'd2;
                                    r_y <= r_y - 1'b1;
                                end
                            end else r_x <= r_x + 1'b1;
                        end
                    endcase
                end
                S_RRD: r_state <= S_RWAIT;
                S_RWAIT: begin
                    r_px <= r_rx;
                    r_py <= r_ry;
                    r_state <= (r_grid) ? S_SQO : S_SQI;
                end
                S_SQO: begin
                    if (!r_sq_go && !w_sq_busy) begin
                        r_sq_in <= w_lsq;
                        r_sq_go <= 1'b1;
                        r_state <= S_SQI;
                        r_grid  <= 1'b0;
                    end
                end
                S_SQI: begin
                    if (!r_sq_go && !w_sq_busy) begin
                        if (r_grid == 1'b0 && r_op) begin
                            r_ro    <= w_root;
                            r_op    <= 1'b0;
                            r_state <= S_RRD;
                        end else begin
                            r_sq_in <= w_lsq;
                            r_sq_go <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_sq_go && !w_sq_busy) begin
                        r_dv <= (w_d < 0) ? 8'd0 : (w_d > 255) ? 8'd255 : w_d[7:0];
                        r_last <= (32'(r_ridx) == 32'(w_total) - 1);
                        r_rdy  <= 1'b1;
                        r_valid <= 1'b1;
                        r_ridx <= (32'(r_ridx) + 1 >= 32'(w_total)) ? '0 : r_ridx + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_distance_value = r_dv;
    assign o_frame_last     = r_last;
    assign o_ready_res      = r_rdy;
endmodule

>>> tb/sdf8_distance_checker.sv
//------------------------------------------------------------------------------
// sdf8_distance_checker
// Watches the command, configuration and result ports of the 8SSEDT unit. It
// keeps its own grids, runs the two-pass transform when a frame completes,
// and compares every result transaction field by field in order.
//------------------------------------------------------------------------------
module sdf8_distance_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic       i_operation,
    input  logic [7:0] i_pixel,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data,
    input  logic       i_valid,
    input  logic [7:0] i_distance_value,
    input  logic       i_frame_last,
    input  logic       i_ready_res,
    output int         o_fail_count,
    output int         o_pending
);
    localparam int CELLS = sdf8_pkg::MAX_WIDTH_DEF * sdf8_pkg::MAX_HEIGHT_DEF;

    typedef struct {
        logic [7:0] distance;
        logic       last;
        logic       ready;
    } t_pixel_result;

    t_pixel_result distance_q[$];

    int vec_dx [2][CELLS];
    int vec_dy [2][CELLS];
    int load_count;
    int read_index;
    bit frame_done;
    int threshold;
    int width_reg;
    int height_reg;
    int bias;

    assign o_pending = distance_q.size();

    function automatic int wrap_coord(int v);
        logic [15:0] t;
        t = v[15:0];
        return int'($signed(t));
    endfunction

    function automatic int clamp_dim(int v, int max_v);
        if (v < 1) return 1;
        if (v > max_v) return max_v;
        return v;
    endfunction

    function automatic longint len_sq(int x, int y);
        return longint'(x) * x + longint'(y) * y;
    endfunction

    function automatic void relax(int g, int x, int y, int ox, int oy, int w, int h,
                                  inout int px, inout int py);
        int nx, ny;
        if (x + ox < 0 || y + oy < 0 || x + ox >= w || y + oy >= h) begin
            nx = sdf8_pkg::FAR_COORD;
            ny = sdf8_pkg::FAR_COORD;
        end else begin
            nx = vec_dx[g][(y + oy) * w + x + ox];
            ny = vec_dy[g][(y + oy) * w + x + ox];
        end
        nx = wrap_coord(nx + ox);
        ny = wrap_coord(ny + oy);
        if (len_sq(nx, ny) < len_sq(px, py)) begin
            px = nx;
            py = ny;
        end
    endfunction

    function automatic void sweep_grid(int g, int w, int h);
        int px, py;
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                px = vec_dx[g][y * w + x];
                py = vec_dy[g][y * w + x];
                relax(g, x, y, -1, 0, w, h, px, py);
                relax(g, x, y, 0, -1, w, h, px, py);
                relax(g, x, y, -1, -1, w, h, px, py);
                relax(g, x, y, 1, -1, w, h, px, py);
                vec_dx[g][y * w + x] = px;
                vec_dy[g][y * w + x] = py;
            end
            for (int x = w - 1; x >= 0; x--) begin
                px = vec_dx[g][y * w + x];
                py = vec_dy[g][y * w + x];
                relax(g, x, y, 1, 0, w, h, px, py);
                vec_dx[g][y * w + x] = px;
                vec_dy[g][y * w + x] = py;
            end
        end
        for (int y = h - 1; y >= 0; y--) begin
            for (int x = w - 1; x >= 0; x--) begin
                px = vec_dx[g][y * w + x];
                py = vec_dy[g][y * w + x];
                relax(g, x, y, 1, 0, w, h, px, py);
                relax(g, x, y, 0, 1, w, h, px, py);
                relax(g, x, y, -1, 1, w, h, px, py);
                relax(g, x, y, 1, 1, w, h, px, py);
                vec_dx[g][y * w + x] = px;
                vec_dy[g][y * w + x] = py;
            end
            for (int x = 0; x < w; x++) begin
                px = vec_dx[g][y * w + x];
                py = vec_dy[g][y * w + x];
                relax(g, x, y, -1, 0, w, h, px, py);
                vec_dx[g][y * w + x] = px;
                vec_dy[g][y * w + x] = py;
            end
        end
    endfunction

    function automatic longint floor_sqrt(longint n);
        longint r;
        r = 0;
        for (longint b = longint'(1) << 31; b > 0; b = b >> 1) begin
            if ((r + b) * (r + b) <= n) r = r + b;
        end
        return r;
    endfunction

    function automatic t_pixel_result predict_read();
        t_pixel_result res;
        int w, h, total, idx;
        longint d;
        w = clamp_dim(width_reg, sdf8_pkg::MAX_WIDTH_DEF);
        h = clamp_dim(height_reg, sdf8_pkg::MAX_HEIGHT_DEF);
        total = w * h;
        res = '{distance: 8'd0, last: 1'b0, ready: 1'b0};
        if (frame_done) begin
            idx = (read_index >= total) ? 0 : read_index;
            d = floor_sqrt(len_sq(vec_dx[1][idx], vec_dy[1][idx]))
              - floor_sqrt(len_sq(vec_dx[0][idx], vec_dy[0][idx])) + bias;
            if (d < 0) d = 0;
            if (d > 255) d = 255;
            res.distance = 8'(d);
            res.last = (idx == total - 1);
            res.ready = 1'b1;
            read_index = (idx + 1 >= total) ? 0 : idx + 1;
        end
        return res;
    endfunction

    function automatic void load_pixel(logic [7:0] px);
        int w, h, total;
        bit in_shape;
        w = clamp_dim(width_reg, sdf8_pkg::MAX_WIDTH_DEF);
        h = clamp_dim(height_reg, sdf8_pkg::MAX_HEIGHT_DEF);
        total = w * h;
        if (load_count == 0) begin
            frame_done = 1'b0;
            read_index = 0;
        end
        if (load_count >= total) load_count = 0;
        in_shape = (int'(px) < threshold);
        vec_dx[0][load_count] = in_shape ? 0 : sdf8_pkg::FAR_COORD;
        vec_dy[0][load_count] = in_shape ? 0 : sdf8_pkg::FAR_COORD;
        vec_dx[1][load_count] = in_shape ? sdf8_pkg::FAR_COORD : 0;
        vec_dy[1][load_count] = in_shape ? sdf8_pkg::FAR_COORD : 0;
        load_count++;
        if (load_count == total) begin
            sweep_grid(0, w, h);
            sweep_grid(1, w, h);
            frame_done = 1'b1;
            read_index = 0;
            load_count = 0;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pixel_result got, want, next_res;
        if (!i_rst_n) begin
            load_count   = 0;
            read_index   = 0;
            frame_done   = 1'b0;
            threshold    = 128;
            width_reg    = 256;
            height_reg   = 256;
            bias         = 128;
            o_fail_count <= 0;
            distance_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sdf8_pkg::REG_THRESHOLD: threshold = int'(i_cfg_data[7:0]);
                    sdf8_pkg::REG_WIDTH, sdf8_pkg::REG_HEIGHT: begin
                        if (i_cfg_index == sdf8_pkg::REG_WIDTH) width_reg = int'(i_cfg_data);
                        else height_reg = int'(i_cfg_data);
                        load_count = 0;
                        read_index = 0;
                        frame_done = 1'b0;
                    end
                    sdf8_pkg::REG_BIAS: bias = int'(i_cfg_data[7:0]);
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (i_operation == sdf8_pkg::OP_LOAD) begin
                    load_pixel(i_pixel);
                end else begin
                    next_res = predict_read();
                    distance_q.insert(distance_q.size(), next_res);
                end
            end
            if (i_valid) begin
                got = '{distance: i_distance_value, last: i_frame_last, ready: i_ready_res};
                if (distance_q.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, actual %0d/%0b/%0b",
                             $time, got.distance, got.last, got.ready);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = distance_q.pop_front();
                    if (want.distance !== got.distance || want.last !== got.last
                        || want.ready !== got.ready) begin
                        $display("%0t: distance mismatch, expected %0d/%0b/%0b, actual %0d/%0b/%0b",
                                 $time, want.distance, want.last, want.ready,
                                 got.distance, got.last, got.ready);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb_signed_distance_field_8ssedt_unit.sv
//------------------------------------------------------------------------------
// tb_signed_distance_field_8ssedt_unit
// Drives frames of random size and content through the 8SSEDT unit, with
// directed geometry, threshold and bias extremes, random bursts and gaps,
// and reads interleaved with loads. The checker judges every result.
//------------------------------------------------------------------------------
module tb_signed_distance_field_8ssedt_unit;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    logic       i_operation = sdf8_pkg::OP_LOAD;
    logic [7:0] i_pixel = 8'd0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = sdf8_pkg::REG_THRESHOLD;
    logic [8:0] i_cfg_data = 9'd0;
    logic       o_busy, o_valid, o_frame_last, o_ready_res;
    logic [7:0] o_distance_value;
    int         fail_count, pending;
    int         items_sent = 0;
    int         burst_left = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    signed_distance_field_8ssedt_unit u_dut (.*);

    sdf8_distance_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_operation(i_operation), .i_pixel(i_pixel), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .i_valid(o_valid),
        .i_distance_value(o_distance_value), .i_frame_last(o_frame_last),
        .i_ready_res(o_ready_res), .o_fail_count(fail_count), .o_pending(pending)
    );

    task automatic send(logic op, logic [7:0] px);
        i_start     <= 1'b1;
        i_operation <= op;
        i_pixel     <= px;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
            if ($urandom_range(0, 2) != 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 30 : 5))
                    @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || o_busy) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] shape_pixel(int density);
        return ($urandom_range(0, 99) < density) ? 8'($urandom_range(0, 127))
                                                 : 8'($urandom_range(128, 255));
    endfunction

    task automatic run_frame(int w, int h, int reads, bit mixed);
        int density;
        density = $urandom_range(0, 100);
        for (int k = 0; k < w * h; k++) begin
            send(sdf8_pkg::OP_LOAD, shape_pixel(density));
            if (mixed && $urandom_range(0, 7) == 0) send(sdf8_pkg::OP_READ, 8'($urandom));
        end
        for (int k = 0; k < reads; k++) send(sdf8_pkg::OP_READ, 8'($urandom));
    endtask

    initial begin
        int w, h;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(sdf8_pkg::OP_READ, 8'hFF);
        write_reg(sdf8_pkg::REG_WIDTH, 9'd3);
        write_reg(sdf8_pkg::REG_HEIGHT, 9'd3);
        send(sdf8_pkg::OP_LOAD, 8'd0);
        send(sdf8_pkg::OP_READ, 8'd0);
        send(sdf8_pkg::OP_LOAD, 8'd255);
        send(sdf8_pkg::OP_LOAD, 8'd127);
        send(sdf8_pkg::OP_LOAD, 8'd128);
        write_reg(sdf8_pkg::REG_HEIGHT, 9'd2);
        run_frame(3, 2, 8, 0);
        send(sdf8_pkg::OP_LOAD, 8'd1);
        send(sdf8_pkg::OP_READ, 8'd0);
        write_reg(sdf8_pkg::REG_THRESHOLD, 9'd0);
        write_reg(sdf8_pkg::REG_BIAS, 9'd0);
        run_frame(3, 2, 2, 0);
        write_reg(sdf8_pkg::REG_THRESHOLD, 9'd255);
        write_reg(sdf8_pkg::REG_BIAS, 9'd255);
        run_frame(3, 2, 2, 0);
        write_reg(sdf8_pkg::REG_WIDTH, 9'd0);
        write_reg(sdf8_pkg::REG_HEIGHT, 9'd0);
        write_reg(sdf8_pkg::REG_THRESHOLD, 9'h1FF);
        send(sdf8_pkg::OP_LOAD, 8'd254);
        send(sdf8_pkg::OP_READ, 8'd0);
        send(sdf8_pkg::OP_READ, 8'd0);
        write_reg(sdf8_pkg::REG_THRESHOLD, 9'd128);
        write_reg(sdf8_pkg::REG_BIAS, 9'd128);
        write_reg(sdf8_pkg::REG_WIDTH, 9'h1FF);
        write_reg(sdf8_pkg::REG_HEIGHT, 9'd1);
        run_frame(256, 1, 10, 0);
        write_reg(sdf8_pkg::REG_WIDTH, 9'd1);
        write_reg(sdf8_pkg::REG_HEIGHT, 9'h1FF);
        run_frame(1, 256, 10, 0);

        while (items_sent < 750) begin
            if ($urandom_range(0, 3) == 0) write_reg(sdf8_pkg::REG_THRESHOLD, 9'($urandom));
            if ($urandom_range(0, 3) == 0) write_reg(sdf8_pkg::REG_BIAS, 9'($urandom));
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
            write_reg(sdf8_pkg::REG_WIDTH, 9'(w));
            write_reg(sdf8_pkg::REG_HEIGHT, 9'(h));
            if ($urandom_range(0, 5) == 0) begin
                run_frame(w, h, 0, 1);
                write_reg(sdf8_pkg::REG_HEIGHT, 9'(h));
            end
            run_frame(w, h, $urandom_range(0, w * h + 3), $urandom_range(0, 1));
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #100000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> signed_distance_field_8ssedt_unit.f
hdl/sdf8_pkg.sv
hdl/sdf8_isqrt.sv
hdl/sdf8_relax.sv
hdl/signed_distance_field_8ssedt_unit.sv
tb/sdf8_distance_checker.sv
tb/tb_signed_distance_field_8ssedt_unit.sv
